>>> hdl/hmis_pkg.sv
`timescale 1ns / 1ps
package hmis_pkg;

  localparam int DEF_MAX_ELEMS = 64;
  localparam int VALUE_W       = 32;
  localparam int TALLY_W       = 16;
  localparam int LIMIT_W       = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd5;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_POP, S_DEC, S_INS_I, S_INS_KEY, S_INS_CMP, S_INS_PLACE,
    S_MC_RD, S_MC_WR, S_MI0, S_MI1, S_MR_LD, S_ML_LD, S_MSTEP, S_ORD, S_OLAT,
    S_OWAIT
  } state_t;

  typedef enum logic [4:0] {
    OP_LOAD, OP_INIT, OP_POP, OP_DEC, OP_INS_I, OP_INS_KEY, OP_INS_CMP,
    OP_INS_PLACE, OP_MC_RD, OP_MC_WR, OP_MI0, OP_MI1, OP_MR_LD, OP_ML_LD,
    OP_MSTEP, OP_ORD, OP_OLAT, OP_OWAIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_fire;
    logic out_fire;
  } cmd_t;

  typedef struct packed {
    logic sp_empty;
    logic top_ph;
    logic leaf;
    logic i_gt_hi;
    logic gt_key;
    logic j_next_lo;
    logic c_last;
    logic l_av;
    logic r_av;
    logic gt_m;
    logic l_more;
    logic r_more;
    logic o_last;
  } status_t;

  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
    sat_inc = (v == {TALLY_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

>>> hdl/hmis_ctrl.sv
`timescale 1ns / 1ps
module hmis_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_is_last,
  input  logic             out_ready,
  input  hmis_pkg::status_t st,
  output hmis_pkg::cmd_t    cmd,
  output logic             in_ready,
  output logic             out_valid
);
  import hmis_pkg::*;

  state_t state_r, state_nxt;
  logic in_fire, out_fire;

  assign in_fire  = in_valid && (state_r == S_LOAD);
  assign out_fire = out_ready && (state_r == S_OWAIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:      if (in_fire && in_is_last) state_nxt = S_INIT;
      S_INIT:      state_nxt = S_POP;
      S_POP:       state_nxt = st.sp_empty ? S_ORD : S_DEC;
      S_DEC: begin
        if (st.top_ph) state_nxt = S_MC_RD;
        else if (st.leaf) state_nxt = S_INS_I;
        else state_nxt = S_POP;
      end
      S_INS_I:     state_nxt = st.i_gt_hi ? S_POP : S_INS_KEY;
      S_INS_KEY:   state_nxt = S_INS_CMP;
      S_INS_CMP: begin
        if (st.gt_key && !st.j_next_lo) state_nxt = S_INS_CMP;
        else state_nxt = S_INS_PLACE;
      end
      S_INS_PLACE: state_nxt = S_INS_I;
      S_MC_RD:     state_nxt = S_MC_WR;
      S_MC_WR:     state_nxt = st.c_last ? S_MI0 : S_MC_RD;
      S_MI0:       state_nxt = S_MI1;
      S_MI1:       state_nxt = S_MR_LD;
      S_MR_LD:     state_nxt = S_MSTEP;
      S_ML_LD:     state_nxt = S_MSTEP;
      S_MSTEP: begin
        if (st.l_av && st.r_av) begin
          if (st.gt_m) state_nxt = st.r_more ? S_MR_LD : S_MSTEP;
          else state_nxt = st.l_more ? S_ML_LD : S_MSTEP;
        end else if (st.l_av) begin
          state_nxt = st.l_more ? S_ML_LD : S_MSTEP;
        end else if (st.r_av) begin
          state_nxt = st.r_more ? S_MR_LD : S_MSTEP;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_ORD:       state_nxt = S_OLAT;
      S_OLAT:      state_nxt = S_OWAIT;
      S_OWAIT: begin
        if (out_fire) state_nxt = st.o_last ? S_LOAD : S_ORD;
      end
      default:     state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd.in_fire  = in_fire;
    cmd.out_fire = out_fire;
    in_ready     = (state_r == S_LOAD);
    out_valid    = (state_r == S_OWAIT);
    unique case (state_r)
      S_LOAD:      cmd.op = OP_LOAD;
      S_INIT:      cmd.op = OP_INIT;
      S_POP:       cmd.op = OP_POP;
      S_DEC:       cmd.op = OP_DEC;
      S_INS_I:     cmd.op = OP_INS_I;
      S_INS_KEY:   cmd.op = OP_INS_KEY;
      S_INS_CMP:   cmd.op = OP_INS_CMP;
      S_INS_PLACE: cmd.op = OP_INS_PLACE;
      S_MC_RD:     cmd.op = OP_MC_RD;
      S_MC_WR:     cmd.op = OP_MC_WR;
      S_MI0:       cmd.op = OP_MI0;
      S_MI1:       cmd.op = OP_MI1;
      S_MR_LD:     cmd.op = OP_MR_LD;
      S_ML_LD:     cmd.op = OP_ML_LD;
      S_MSTEP:     cmd.op = OP_MSTEP;
      S_ORD:       cmd.op = OP_ORD;
      S_OLAT:      cmd.op = OP_OLAT;
      S_OWAIT:     cmd.op = OP_OWAIT;
      default:     cmd.op = OP_LOAD;
    endcase
  end

endmodule

>>> hdl/hmis_datapath.sv
`timescale 1ns / 1ps
module hmis_datapath #(
  parameter int MAX_ELEMS = hmis_pkg::DEF_MAX_ELEMS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hmis_pkg::cmd_t                      cmd,
  output hmis_pkg::status_t                   st,
  input  logic                                cfg_we,
  input  logic [hmis_pkg::LIMIT_W-1:0]        cfg_wdata,
  input  logic signed [hmis_pkg::VALUE_W-1:0] in_value,
  output logic signed [hmis_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                                out_last,
  output logic [hmis_pkg::TALLY_W-1:0]        out_compare_count,
  output logic [hmis_pkg::TALLY_W-1:0]        out_move_count
);
  import hmis_pkg::*;

  localparam int AW  = $clog2(MAX_ELEMS);
  localparam int IW  = $clog2(MAX_ELEMS + 1);
  localparam int SD  = 2 * AW + 3;
  localparam int SIW = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);

  logic signed [VALUE_W-1:0] store_mem   [MAX_ELEMS];
  logic signed [VALUE_W-1:0] scratch_mem [MAX_ELEMS];
  logic signed [VALUE_W-1:0] rd_r, sd_r, key_r, lv_r, rv_r, st_wdata;
  logic [AW-1:0] st_raddr, st_waddr, sc_raddr;
  logic          st_we, sc_we;

  logic [IW-1:0] stk_lo [SD];
  logic [IW-1:0] stk_hi [SD];
  logic          stk_ph [SD];
  logic [SPW-1:0] sp_r;
  logic [SIW-1:0] top_idx, p0, p1, p2;

  logic [IW-1:0] cnt_r, lo_r, hi_r, mid_r, i_r, j_r, k_r, c_r;
  logic [IW-1:0] mid_c, len_c, jm1, jm2;
  logic          ph_r;
  logic [LIMIT_W-1:0] lim_r, lim_eff;
  logic [TALLY_W-1:0] ccnt_r, mcnt_r;
  logic take_l, take_r;

  assign top_idx = SIW'(sp_r - 1'b1);
  assign p0      = SIW'(sp_r);
  assign p1      = SIW'(sp_r + SPW'(1));
  assign p2      = SIW'(sp_r + SPW'(2));
  assign mid_c   = lo_r + ((hi_r - lo_r) >> 1);
  assign len_c   = hi_r - lo_r + 1'b1;
  assign jm1     = j_r - 1'b1;
  assign jm2     = j_r - IW'(2);
  assign lim_eff = (lim_r == '0) ? LIMIT_W'(1) : lim_r;

  always_comb begin
    st.sp_empty  = (sp_r == '0);
    st.top_ph    = ph_r;
    st.leaf      = ({{LIMIT_W{1'b0}}, len_c} <= {{IW{1'b0}}, lim_eff});
    st.i_gt_hi   = (i_r > hi_r);
    st.gt_key    = (rd_r > key_r);
    st.j_next_lo = (jm1 == lo_r);
    st.c_last    = (c_r == hi_r);
    st.l_av      = (i_r <= mid_r);
    st.r_av      = (j_r <= hi_r);
    st.gt_m      = (lv_r > rv_r);
    st.l_more    = (({1'b0, i_r} + 1'b1) <= {1'b0, mid_r});
    st.r_more    = (({1'b0, j_r} + 1'b1) <= {1'b0, hi_r});
    st.o_last    = (k_r == cnt_r - 1'b1);
  end

  assign take_l = st.l_av && (!st.r_av || !st.gt_m);
  assign take_r = st.r_av && (!st.l_av || st.gt_m);

  // memory port selection
  always_comb begin
    st_raddr = '0;
    st_waddr = '0;
    st_we    = 1'b0;
    st_wdata = rd_r;
    sc_raddr = '0;
    sc_we    = 1'b0;
    case (cmd.op)
      OP_LOAD: begin
        st_we    = cmd.in_fire && (cnt_r < IW'(MAX_ELEMS));
        st_waddr = cnt_r[AW-1:0];
        st_wdata = in_value;
      end
      OP_INS_I:   st_raddr = i_r[AW-1:0];
      OP_INS_KEY: st_raddr = jm1[AW-1:0];
      OP_INS_CMP: begin
        st_raddr = jm2[AW-1:0];
        st_we    = st.gt_key;
        st_waddr = j_r[AW-1:0];
      end
      OP_INS_PLACE: begin
        st_we    = (j_r != i_r);
        st_waddr = j_r[AW-1:0];
        st_wdata = key_r;
      end
      OP_MC_RD: st_raddr = c_r[AW-1:0];
      OP_MC_WR: sc_we = 1'b1;
      OP_MI0:   sc_raddr = i_r[AW-1:0];
      OP_MI1:   sc_raddr = j_r[AW-1:0];
      OP_MSTEP: begin
        st_we    = take_l || take_r;
        st_waddr = k_r[AW-1:0];
        st_wdata = take_l ? lv_r : rv_r;
        sc_raddr = take_l ? AW'(i_r + 1'b1) : AW'(j_r + 1'b1);
      end
      OP_ORD:  st_raddr = k_r[AW-1:0];
      default: st_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    rd_r <= store_mem[st_raddr];
    if (sc_we) scratch_mem[c_r[AW-1:0]] <= rd_r;
    sd_r <= scratch_mem[sc_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r  <= LIMIT_RESET;
      cnt_r  <= '0;
      sp_r   <= '0;
      ccnt_r <= '0;
      mcnt_r <= '0;
    end else begin
      if (cfg_we) lim_r <= cfg_wdata;
      case (cmd.op)
        OP_LOAD: if (cmd.in_fire && (cnt_r < IW'(MAX_ELEMS))) cnt_r <= cnt_r + 1'b1;
        OP_INIT: begin
          stk_lo[0] <= '0;
          stk_hi[0] <= cnt_r - 1'b1;
          stk_ph[0] <= 1'b0;
          sp_r      <= SPW'(1);
          ccnt_r    <= '0;
          mcnt_r    <= '0;
        end
        OP_POP: begin
          if (sp_r != '0) begin
            lo_r <= stk_lo[top_idx];
            hi_r <= stk_hi[top_idx];
            ph_r <= stk_ph[top_idx];
            sp_r <= sp_r - 1'b1;
          end else begin
            k_r <= '0;
          end
        end
        OP_DEC: begin
          mid_r <= mid_c;
          c_r   <= lo_r;
          i_r   <= lo_r + 1'b1;
          if (!ph_r && !st.leaf) begin
            stk_lo[p0] <= lo_r;
            stk_hi[p0] <= hi_r;
            stk_ph[p0] <= 1'b1;
            stk_lo[p1] <= mid_c + 1'b1;
            stk_hi[p1] <= hi_r;
            stk_ph[p1] <= 1'b0;
            stk_lo[p2] <= lo_r;
            stk_hi[p2] <= mid_c;
            stk_ph[p2] <= 1'b0;
            sp_r       <= sp_r + SPW'(3);
          end
        end
        OP_INS_I:   j_r <= i_r;
        OP_INS_KEY: key_r <= rd_r;
        OP_INS_CMP: begin
          ccnt_r <= sat_inc(ccnt_r);
          if (st.gt_key) begin
            mcnt_r <= sat_inc(mcnt_r);
            j_r    <= jm1;
          end
        end
        OP_INS_PLACE: begin
          if (j_r != i_r) mcnt_r <= sat_inc(mcnt_r);
          i_r <= i_r + 1'b1;
        end
        OP_MC_WR: begin
          c_r <= c_r + 1'b1;
          i_r <= lo_r;
          j_r <= mid_r + 1'b1;
          k_r <= lo_r;
        end
        OP_MI1:   lv_r <= sd_r;
        OP_MR_LD: rv_r <= sd_r;
        OP_ML_LD: lv_r <= sd_r;
        OP_MSTEP: begin
          if (st.l_av && st.r_av) ccnt_r <= sat_inc(ccnt_r);
          if (take_l || take_r) begin
            mcnt_r <= sat_inc(mcnt_r);
            k_r    <= k_r + 1'b1;
          end
          if (take_l) i_r <= i_r + 1'b1;
          if (take_r) j_r <= j_r + 1'b1;
        end
        OP_OWAIT: begin
          if (cmd.out_fire) begin
            k_r <= k_r + 1'b1;
            if (st.o_last) cnt_r <= '0;
          end
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OLAT) begin
      out_sorted_value  <= rd_r;
      out_last          <= st.o_last;
      out_compare_count <= ccnt_r;
      out_move_count    <= mcnt_r;
    end
  end

endmodule

>>> hdl/hybrid_merge_insertion_sort_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    in_value[31:0] signed, in_is_last
// out       out  out_valid/out_ready  out_sorted_value[31:0] signed, out_last,
//                                     out_compare_count[15:0], out_move_count[15:0]
// cfg       in   cfg_we               cfg_wdata[4:0] insertion run limit
// loading accepts one request per cycle; the sort then runs on a single-read
// store plus a single-read scratch memory: insertion does a compare per step
// plus key fetch and place; each merge level copies to scratch, then merges
// each result is read from the store and registered, then held until out_ready
// synchronous active-low reset clears control state; stores need no clearing
module hybrid_merge_insertion_sort_core #(
  parameter int MAX_ELEMS = hmis_pkg::DEF_MAX_ELEMS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hmis_pkg::LIMIT_W-1:0]        cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [hmis_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_is_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hmis_pkg::VALUE_W-1:0] out_sorted_value,
  output logic                                out_last,
  output logic [hmis_pkg::TALLY_W-1:0]        out_compare_count,
  output logic [hmis_pkg::TALLY_W-1:0]        out_move_count
);
  import hmis_pkg::*;

  cmd_t    cmd;
  status_t st;

  hmis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_is_last),
    .out_ready  (out_ready),
    .st         (st),
    .cmd        (cmd),
    .in_ready   (in_ready),
    .out_valid  (out_valid)
  );

  hmis_datapath #(.MAX_ELEMS(MAX_ELEMS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_value          (in_value),
    .out_sorted_value  (out_sorted_value),
    .out_last          (out_last),
    .out_compare_count (out_compare_count),
    .out_move_count    (out_move_count)
  );

endmodule
